FILE: design/tprm_pkg.sv
`timescale 1ns / 1ps

package tprm_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int TIME_BITS_DEF  = 32;

	localparam int CFG_ADDR_BITS = 4;
	localparam int CFG_DATA_BITS = 32;

	localparam int SPLIT_BITS = 12;
	localparam int OUT_BITS   = 24;

	localparam logic [2:0]  PAD_MODE_RST    = 3'd0;
	localparam logic [7:0]  SENSITIVITY_RST = 8'd8;
	localparam logic [15:0] LONG_PRESS_RST  = 16'd400;
	localparam logic [11:0] SPLIT_X_RST     = 12'd960;

	localparam logic [7:0] GAIN_DEFAULT = 8'd8;

	localparam logic [2:0] MODE_LEFT_HALF  = 3'd2;
	localparam logic [2:0] MODE_RIGHT_HALF = 3'd3;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [2:0] BTN_NONE  = 3'b000;
	localparam logic [2:0] BTN_LEFT  = 3'b001;
	localparam logic [2:0] BTN_RIGHT = 3'b010;

	typedef enum logic [1:0] {
		REG_PAD_MODE    = 2'd0,
		REG_SENSITIVITY = 2'd1,
		REG_LONG_PRESS  = 2'd2,
		REG_SPLIT_X     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  pad_mode;
		logic [7:0]  sensitivity;
		logic [15:0] long_press_ms;
		logic [11:0] split_x;
	} cfg_t;

endpackage

FILE: design/tprm_cfg.sv
`timescale 1ns / 1ps

module tprm_cfg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [tprm_pkg::CFG_ADDR_BITS-1:0]     paddr,
	input  logic [tprm_pkg::CFG_DATA_BITS-1:0]     pwdata,
	output logic [tprm_pkg::CFG_DATA_BITS-1:0]     prdata,
	output logic                                   pready,
	output tprm_pkg::cfg_t                         cfg
);
	import tprm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pad_mode      <= PAD_MODE_RST;
			cfg_q.sensitivity   <= SENSITIVITY_RST;
			cfg_q.long_press_ms <= LONG_PRESS_RST;
			cfg_q.split_x       <= SPLIT_X_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_PAD_MODE:    cfg_q.pad_mode      <= pwdata[2:0];
				REG_SENSITIVITY: cfg_q.sensitivity   <= pwdata[7:0];
				REG_LONG_PRESS:  cfg_q.long_press_ms <= pwdata[15:0];
				REG_SPLIT_X:     cfg_q.split_x       <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_PAD_MODE:    prdata = CFG_DATA_BITS'(cfg_q.pad_mode);
			REG_SENSITIVITY: prdata = CFG_DATA_BITS'(cfg_q.sensitivity);
			REG_LONG_PRESS:  prdata = CFG_DATA_BITS'(cfg_q.long_press_ms);
			REG_SPLIT_X:     prdata = CFG_DATA_BITS'(cfg_q.split_x);
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: design/tprm_scale.sv
`timescale 1ns / 1ps

// (cur - old) * gain / 16, truncated toward zero, clamped to +-127
module tprm_scale #(
	parameter int COORD_BITS = tprm_pkg::COORD_BITS_DEF
) (
	input  logic [COORD_BITS-1:0] cur,
	input  logic [COORD_BITS-1:0] old,
	input  logic [7:0]            gain,
	output logic signed [7:0]     move
);
	import tprm_pkg::*;

	localparam int PW = COORD_BITS + 10;

	logic signed [COORD_BITS:0] diff;
	logic signed [PW-1:0]       diff_ext;
	logic signed [PW-1:0]       gain_ext;
	logic signed [PW-1:0]       prod;
	logic signed [PW-1:0]       biased;
	logic signed [PW-1:0]       quot;

	assign diff     = $signed({1'b0, cur}) - $signed({1'b0, old});
	assign diff_ext = PW'(diff);
	assign gain_ext = $signed({{(PW-8){1'b0}}, gain});
	assign prod     = PW'(diff_ext * gain_ext);
	// bias negatives so the arithmetic shift rounds toward zero
	assign biased   = prod[PW-1] ? PW'(prod + PW'(15)) : prod;
	assign quot     = biased >>> 4;

	always_comb begin
		if (quot > PW'(127))
			move = 8'sd127;
		else if (quot < -PW'(127))
			move = -8'sd127;
		else
			move = quot[7:0];
	end

endmodule

FILE: design/tprm_core.sv
`timescale 1ns / 1ps

module tprm_core #(
	parameter int COORD_BITS = tprm_pkg::COORD_BITS_DEF,
	parameter int TIME_BITS  = tprm_pkg::TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  tprm_pkg::cfg_t        cfg,
	input  logic                  operation,
	input  logic                  finger_down,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic                  pad_click,
	input  logic [TIME_BITS-1:0]  now_ms,
	input  logic [2:0]            extra_buttons,
	input  logic                  host_ready,
	output logic                  emit,
	output logic [2:0]            buttons,
	output logic signed [7:0]     move_x,
	output logic signed [7:0]     move_y
);
	import tprm_pkg::*;

	localparam int CMP_BITS = (COORD_BITS > SPLIT_BITS) ? COORD_BITS : SPLIT_BITS;

	logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic                  prev_valid_q;
	logic                  click_held_q;
	logic                  right_fired_q;
	logic [TIME_BITS-1:0]  press_start_q;
	logic [2:0]            sent_buttons_q;

	logic                  active, in_zone, press, rf_base, rf_new, report;
	logic [7:0]            gain;
	logic signed [7:0]     sx, sy;
	logic [TIME_BITS-1:0]  start_eff, elapsed;
	logic [2:0]            btn;

	tprm_scale #(.COORD_BITS(COORD_BITS)) u_scale_x (
		.cur(pos_x), .old(prev_x_q), .gain(gain), .move(sx)
	);
	tprm_scale #(.COORD_BITS(COORD_BITS)) u_scale_y (
		.cur(pos_y), .old(prev_y_q), .gain(gain), .move(sy)
	);

	assign active = (cfg.pad_mode == MODE_LEFT_HALF) || (cfg.pad_mode == MODE_RIGHT_HALF);
	assign gain   = (cfg.sensitivity == 8'd0) ? GAIN_DEFAULT : cfg.sensitivity;

	always_comb begin
		in_zone = 1'b0;
		if (finger_down) begin
			if (cfg.pad_mode == MODE_LEFT_HALF)
				in_zone = CMP_BITS'(pos_x) < CMP_BITS'(cfg.split_x);
			else
				in_zone = CMP_BITS'(pos_x) >= CMP_BITS'(cfg.split_x);
		end
	end

	assign move_x = (operation == OP_TICK && in_zone && prev_valid_q) ? sx : 8'sd0;
	assign move_y = (operation == OP_TICK && in_zone && prev_valid_q) ? sy : 8'sd0;

	// a fresh press starts its timer now
	assign press     = pad_click && in_zone;
	assign start_eff = click_held_q ? press_start_q : now_ms;
	assign rf_base   = click_held_q && right_fired_q;
	assign elapsed   = now_ms - start_eff;
	assign rf_new    = rf_base || (elapsed >= TIME_BITS'(cfg.long_press_ms));

	always_comb begin
		if (press)
			btn = rf_new ? BTN_RIGHT : BTN_NONE;
		else if (click_held_q)
			btn = right_fired_q ? BTN_NONE : BTN_LEFT;
		else
			btn = BTN_NONE;
		btn = btn | extra_buttons;
	end

	assign report = (move_x != 8'sd0) || (move_y != 8'sd0) || (btn != sent_buttons_q);

	always_comb begin
		if (operation == OP_CLEAR) begin
			emit    = (sent_buttons_q != BTN_NONE) && host_ready;
			buttons = BTN_NONE;
		end else begin
			emit    = active && report && host_ready;
			buttons = btn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			prev_valid_q   <= 1'b0;
			click_held_q   <= 1'b0;
			right_fired_q  <= 1'b0;
			press_start_q  <= '0;
			sent_buttons_q <= BTN_NONE;
		end else if (en) begin
			if (operation == OP_CLEAR) begin
				prev_x_q       <= '0;
				prev_y_q       <= '0;
				prev_valid_q   <= 1'b0;
				click_held_q   <= 1'b0;
				right_fired_q  <= 1'b0;
				sent_buttons_q <= BTN_NONE;
			end else if (active) begin
				prev_valid_q <= in_zone;
				if (in_zone) begin
					prev_x_q <= pos_x;
					prev_y_q <= pos_y;
				end
				if (press) begin
					click_held_q  <= 1'b1;
					right_fired_q <= rf_new;
					if (!click_held_q)
						press_start_q <= now_ms;
				end else if (click_held_q) begin
					click_held_q <= 1'b0;
				end
				if (report)
					sent_buttons_q <= btn;
			end
		end
	end

endmodule

FILE: design/touchpad_relative_mouse.sv
`timescale 1ns / 1ps

// Path: the input register takes the input transaction; when the output register is free
// or being taken, its result is loaded into the output register, which drives m_tvalid.
// Throughput: one input transaction per cycle; the input stalls only while a result
// waits in the output register with m_tready low.
// Reset (arst_n low): registers return to their reset values, mouse state cleared,
// both pipeline registers empty.
module touchpad_relative_mouse #(
	parameter int COORD_BITS = tprm_pkg::COORD_BITS_DEF,
	parameter int TIME_BITS  = tprm_pkg::TIME_BITS_DEF,
	localparam int IN_W      = ((2 * COORD_BITS + TIME_BITS + 6 + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// finger_down, pos_x, pos_y, pad_click, now_ms, extra_buttons, host_ready
	input  logic [IN_W-1:0]                    s_tdata,
	// operation
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// buttons, move_x, move_y
	output logic [tprm_pkg::OUT_BITS-1:0]      m_tdata,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tprm_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [tprm_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [tprm_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                               pready
);
	import tprm_pkg::*;

	localparam int X_LO   = 1;
	localparam int Y_LO   = X_LO + COORD_BITS;
	localparam int CLK_B  = Y_LO + COORD_BITS;
	localparam int NOW_LO = CLK_B + 1;
	localparam int EXT_LO = NOW_LO + TIME_BITS;
	localparam int RDY_B  = EXT_LO + 3;

	cfg_t cfg;

	logic                  valid_s1;
	logic [IN_W-1:0]       data_s1;
	logic                  op_s1;
	logic                  adv;

	logic                  emit;
	logic [2:0]            res_buttons;
	logic signed [7:0]     res_move_x, res_move_y;

	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   out_data_q;

	tprm_cfg u_cfg (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cfg(cfg)
	);

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			op_s1   <= s_tuser;
		end
	end

	tprm_core #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .en(adv), .cfg(cfg),
		.operation(op_s1),
		.finger_down(data_s1[0]),
		.pos_x(data_s1[X_LO +: COORD_BITS]),
		.pos_y(data_s1[Y_LO +: COORD_BITS]),
		.pad_click(data_s1[CLK_B]),
		.now_ms(data_s1[NOW_LO +: TIME_BITS]),
		.extra_buttons(data_s1[EXT_LO +: 3]),
		.host_ready(data_s1[RDY_B]),
		.emit(emit), .buttons(res_buttons),
		.move_x(res_move_x), .move_y(res_move_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= emit;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && emit)
			out_data_q <= {5'd0, res_move_y, res_move_x, res_buttons};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: tb/touchpad_relative_mouse_tb.sv
`timescale 1ns / 1ps

module touchpad_relative_mouse_tb;
	import tprm_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT       = 400000;
	localparam int SETTLE      = 8;

	localparam logic [2:0] MODE_INACTIVE_A = 3'd1;
	localparam logic [2:0] MODE_INACTIVE_B = 3'd4;

	typedef struct packed {
		logic        op;
		logic        finger;
		logic [11:0] x;
		logic [11:0] y;
		logic        click;
		logic [31:0] now;
		logic [2:0]  extra;
		logic        ready;
	} frame_t;

	typedef struct packed {
		logic [2:0]        btn;
		logic signed [7:0] mx;
		logic signed [7:0] my;
	} report_t;

	logic                     clk      = 1'b0;
	logic                     arst_n   = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [63:0]              s_tdata  = '0;
	logic                     s_tuser  = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_BITS-1:0]      m_tdata;
	logic                     psel     = 1'b0;
	logic                     penable  = 1'b0;
	logic                     pwrite   = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr    = '0;
	logic [CFG_DATA_BITS-1:0] pwdata   = '0;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;

	touchpad_relative_mouse dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	frame_t  frame_q[$];
	report_t report_q[$];
	frame_t  cur_frame;
	report_t want;

	cfg_t cfg = '{PAD_MODE_RST, SENSITIVITY_RST, LONG_PRESS_RST, SPLIT_X_RST};

	// mirror of the mouse state
	logic [11:0] last_x       = '0;
	logic [11:0] last_y       = '0;
	logic        last_valid   = 1'b0;
	logic        click_down   = 1'b0;
	logic        right_done   = 1'b0;
	logic [31:0] press_t      = '0;
	logic [2:0]  reported_btn = BTN_NONE;

	logic        quiet     = 1'b0;
	logic        hold_tog  = 1'b0;
	logic        hold_seen = 1'b0;
	int          hold_left = 0;
	logic [31:0] t_ms      = '0;
	int          n_err     = 0;
	int          n_sent    = 0;
	int          n_checked = 0;
	int          n_cfg     = 0;
	int          n_queued  = 0;
	int          cycles    = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [7:0] scaled_delta(logic [11:0] cur, logic [11:0] old,
			int gain);
		int q;
		q = (int'(cur) - int'(old)) * gain / 16;
		if (q > 127)
			q = 127;
		else if (q < -127)
			q = -127;
		return q[7:0];
	endfunction

	function automatic void mouse_step(frame_t f);
		logic              in_zone;
		logic [2:0]        btn;
		logic signed [7:0] mx;
		logic signed [7:0] my;
		int                gain;
		in_zone = 1'b0;
		btn = BTN_NONE;
		mx = '0;
		my = '0;
		if (f.op == OP_CLEAR) begin
			if (reported_btn != BTN_NONE && f.ready)
				report_q.push_back('{BTN_NONE, 8'sd0, 8'sd0});
			last_x = '0;
			last_y = '0;
			last_valid = 1'b0;
			click_down = 1'b0;
			right_done = 1'b0;
			reported_btn = BTN_NONE;
			return;
		end
		if (cfg.pad_mode != MODE_LEFT_HALF && cfg.pad_mode != MODE_RIGHT_HALF)
			return;
		if (f.finger)
			in_zone = (cfg.pad_mode == MODE_LEFT_HALF) ? (f.x < cfg.split_x)
				: (f.x >= cfg.split_x);
		gain = (cfg.sensitivity == 0) ? int'(GAIN_DEFAULT) : int'(cfg.sensitivity);
		if (in_zone) begin
			if (last_valid) begin
				mx = scaled_delta(f.x, last_x, gain);
				my = scaled_delta(f.y, last_y, gain);
			end
			last_x = f.x;
			last_y = f.y;
			last_valid = 1'b1;
		end else begin
			last_valid = 1'b0;
		end
		if (f.click && in_zone) begin
			if (!click_down) begin
				click_down = 1'b1;
				press_t = f.now;
				right_done = 1'b0;
			end
			if (!right_done && (f.now - press_t) >= {16'd0, cfg.long_press_ms})
				right_done = 1'b1;
			if (right_done)
				btn = btn | BTN_RIGHT;
		end else if (click_down) begin
			btn = right_done ? BTN_NONE : BTN_LEFT;
			click_down = 1'b0;
		end
		btn = btn | f.extra;
		if (mx != 0 || my != 0 || btn != reported_btn) begin
			reported_btn = btn;
			if (f.ready)
				report_q.push_back('{btn, mx, my});
		end
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				mouse_step(cur_frame);
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (frame_q.size() != 0 && (quiet || $urandom_range(99) >= 10)) begin
					cur_frame = frame_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_frame.op;
					s_tdata <= {2'b00, cur_frame.ready, cur_frame.extra, cur_frame.now,
						cur_frame.click, cur_frame.y, cur_frame.x, cur_frame.finger};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_checked++;
				if (report_q.size() == 0) begin
					$error("report with nothing pending: %h", m_tdata);
					n_err++;
				end else begin
					want = report_q.pop_front();
					if (m_tdata[2:0] !== want.btn) begin
						$error("buttons expected %0d got %0d", want.btn, m_tdata[2:0]);
						n_err++;
					end
					if (m_tdata[10:3] !== want.mx) begin
						$error("move_x expected %0d got %0d", want.mx, $signed(m_tdata[10:3]));
						n_err++;
					end
					if (m_tdata[18:11] !== want.my) begin
						$error("move_y expected %0d got %0d", want.my,
							$signed(m_tdata[18:11]));
						n_err++;
					end
				end
			end
			if (hold_seen != hold_tog) begin
				hold_seen <= hold_tog;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= 10);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PAD_MODE:    cfg.pad_mode = val[2:0];
			REG_SENSITIVITY: cfg.sensitivity = val[7:0];
			REG_LONG_PRESS:  cfg.long_press_ms = val[15:0];
			REG_SPLIT_X:     cfg.split_x = val[11:0];
		endcase
		n_cfg++;
	endtask

	task automatic set_cfg(logic [2:0] mode, logic [7:0] sens, logic [15:0] hold,
			logic [11:0] split);
		apb_write(REG_PAD_MODE, 32'(mode));
		apb_write(REG_SENSITIVITY, 32'(sens));
		apb_write(REG_LONG_PRESS, 32'(hold));
		apb_write(REG_SPLIT_X, 32'(split));
	endtask

	// wait for the pipeline to drain, including frames that give no report
	task automatic settle();
		do
			@(negedge clk);
		while (frame_q.size() != 0 || s_tvalid || report_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_frame(logic op, logic finger, logic [11:0] x, logic [11:0] y,
			logic click, logic [31:0] now, logic [2:0] extra, logic ready);
		frame_q.push_back('{op, finger, x, y, click, now, extra, ready});
		n_queued++;
	endtask

	task automatic advance_time();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			t_ms = t_ms + $urandom_range(30);
		else if (r < 95)
			t_ms = t_ms + $urandom_range(2000);
		else
			t_ms = t_ms + $urandom_range(70000);
	endtask

	function automatic int clamp_coord(int v);
		return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
	endfunction

	function automatic int zone_x();
		if (cfg.pad_mode == MODE_LEFT_HALF && cfg.split_x != 0)
			return $urandom_range(cfg.split_x - 1, 0);
		if (cfg.pad_mode == MODE_RIGHT_HALF)
			return $urandom_range(4095, cfg.split_x);
		return $urandom_range(4095);
	endfunction

	// touch, drag with an optional click, then lift
	task automatic gesture();
		int         steps;
		int         press_at;
		int         release_at;
		int         cx;
		int         cy;
		logic [2:0] extra;
		cx = zone_x();
		cy = $urandom_range(4095);
		steps = $urandom_range(14, 2);
		press_at = $urandom_range(steps + 4);
		release_at = press_at + $urandom_range(steps);
		extra = ($urandom_range(99) < 20) ? 3'($urandom_range(7)) : BTN_NONE;
		for (int i = 0; i < steps; i++) begin
			if ($urandom_range(99) < 8) begin
				cx = $urandom_range(4095);
				cy = $urandom_range(4095);
			end else begin
				cx = clamp_coord(cx + int'($urandom_range(80)) - 40);
				cy = clamp_coord(cy + int'($urandom_range(80)) - 40);
			end
			advance_time();
			push_frame(OP_TICK, 1'b1, cx[11:0], cy[11:0], i >= press_at && i < release_at,
				t_ms, extra, $urandom_range(99) < 90);
		end
		advance_time();
		push_frame(OP_TICK, 1'b0, cx[11:0], cy[11:0], 1'b0, t_ms, extra, 1'b1);
	endtask

	task automatic noise_frame();
		push_frame(($urandom_range(3) == 0) ? OP_CLEAR : OP_TICK, 1'($urandom),
			12'($urandom), 12'($urandom), 1'($urandom), $urandom, 3'($urandom),
			1'($urandom));
	endtask

	task automatic run_phase(logic [2:0] mode, logic [7:0] sens, logic [15:0] hold,
			logic [11:0] split, int n);
		int stop_at;
		set_cfg(mode, sens, hold, split);
		stop_at = n_queued + n;
		while (n_queued < stop_at) begin
			if ($urandom_range(99) < 15)
				noise_frame();
			else
				gesture();
		end
		settle();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset mode is inactive: nothing comes out
		push_frame(OP_TICK, 1'b1, 12'd100, 12'd100, 1'b1, 32'd0, 3'd7, 1'b1);
		push_frame(OP_CLEAR, 1'b0, 12'd0, 12'd0, 1'b0, 32'd0, BTN_NONE, 1'b1);
		settle();

		apb_write(REG_PAD_MODE, 32'(MODE_LEFT_HALF));
		push_frame(OP_TICK, 1'b1, 12'd100, 12'd100, 1'b0, 32'd0, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd116, 12'd84, 1'b0, 32'd10, BTN_NONE, 1'b1);
		// one count of movement truncates to zero either way
		push_frame(OP_TICK, 1'b1, 12'd117, 12'd84, 1'b0, 32'd20, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd116, 12'd84, 1'b0, 32'd30, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd959, 12'd4095, 1'b0, 32'd40, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd0, 12'd0, 1'b0, 32'd50, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd0, 12'd0, 1'b1, 32'd100, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd0, 12'd0, 1'b0, 32'd150, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd0, 12'd0, 1'b0, 32'd160, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd0, 12'd0, 1'b1, 32'd200, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd0, 12'd0, 1'b1, 32'd600, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd0, 12'd0, 1'b0, 32'd610, BTN_NONE, 1'b1);
		// held click dragged out of the mouse half
		push_frame(OP_TICK, 1'b1, 12'd10, 12'd10, 1'b1, 32'd700, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd4095, 12'd10, 1'b1, 32'd710, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b0, 12'd0, 12'd0, 1'b0, 32'd720, BTN_NONE, 1'b1);
		// host busy, then clear with buttons outstanding
		push_frame(OP_TICK, 1'b1, 12'd500, 12'd500, 1'b0, 32'd730, 3'd7, 1'b0);
		push_frame(OP_CLEAR, 1'b0, 12'd0, 12'd0, 1'b0, 32'd740, BTN_NONE, 1'b1);
		push_frame(OP_CLEAR, 1'b0, 12'd0, 12'd0, 1'b0, 32'd750, BTN_NONE, 1'b1);
		// hold timer across the time wrap
		push_frame(OP_TICK, 1'b1, 12'd200, 12'd4095, 1'b1, 32'hFFFF_FFF0, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd200, 12'd4095, 1'b1, 32'h0000_0200, BTN_NONE, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd200, 12'd0, 1'b1, 32'hFFFF_FFFF, 3'd5, 1'b1);
		push_frame(OP_TICK, 1'b1, 12'd200, 12'd0, 1'b0, 32'hFFFF_FFFF, BTN_NONE, 1'b0);
		settle();

		t_ms = $urandom;
		run_phase(MODE_LEFT_HALF, 8'd0, 16'd0, 12'd0, 40);
		run_phase(MODE_RIGHT_HALF, 8'd0, 16'd0, 12'd0, 60);
		run_phase(MODE_RIGHT_HALF, 8'd255, 16'd65535, 12'd4095, 60);
		run_phase(MODE_LEFT_HALF, 8'd255, 16'd65535, 12'd4095, 60);
		run_phase(MODE_LEFT_HALF, 8'd1, 16'd20, 12'd2048, 80);
		quiet = 1'b1;
		run_phase(MODE_RIGHT_HALF, 8'd16, 16'd150, 12'd960, 80);
		quiet = 1'b0;
		run_phase(MODE_INACTIVE_A, 8'd100, 16'd300, 12'd1000, 20);
		run_phase(MODE_INACTIVE_B, 8'd100, 16'd300, 12'd1000, 20);

		// receiver stalls while a steady drag keeps coming
		set_cfg(MODE_LEFT_HALF, 8'd32, 16'd400, 12'd3000);
		@(posedge clk);
		hold_tog <= ~hold_tog;
		for (int i = 0; i < 60; i++) begin
			advance_time();
			push_frame(OP_TICK, 1'b1, 12'(100 + 40 * i), 12'(2000 - 30 * i), 1'b0, t_ms,
				BTN_NONE, 1'b1);
		end
		settle();

		for (int k = 0; k < 6; k++)
			run_phase($urandom_range(1) ? MODE_LEFT_HALF : MODE_RIGHT_HALF,
				8'($urandom), $urandom_range(1) ? 16'($urandom_range(1000)) : 16'($urandom),
				12'($urandom), 60);

		$display("tb: %0d input transactions, %0d reports checked, %0d register writes",
			n_sent, n_checked, n_cfg);
		$display("tb: both halves, inactive modes, gain/hold/split extremes, clears, stalls");
		if (n_err == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: touchpad_relative_mouse.f
design/tprm_pkg.sv
design/tprm_cfg.sv
design/tprm_scale.sv
design/tprm_core.sv
design/touchpad_relative_mouse.sv
tb/touchpad_relative_mouse_tb.sv
